[src/jsu_pkg.sv]
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [15:0] CAP_RESET = 16'd8192;
  localparam logic [16:0] ROOM_MARGIN = 17'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_ROOM = 2'd3;

  // One classified job: zero bytes means an error word.
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic eos;
    logic [1:0] status;
    logic [15:0] len;
  } job_t;

endpackage

[src/json_string_unescape_utf8_unit.sv]
// Top level of the JSON string unescape unit with UTF-8 encoding of \u escapes.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_ready      in_byte, last_byte
//   output    out_valid / out_ready    out_byte, byte_valid, end_of_string,
//                                      status, out_length
//   config    cfg_write                cfg_data (output capacity)
//
// One input word is accepted per cycle while the job queue has room. Each
// accepted byte yields at most one job; a job gives one output word, except
// a completed \u escape, which gives up to three UTF-8 bytes from the output
// stage, one per cycle while the receiver takes them. The first word of a
// result passes through the queue and the output register before it is
// presented. Reset clears the escape state, the byte count, the queue and
// the output valid flag and sets the capacity to 8192. A stall on the output
// fills the queue and then drops in_ready; input gaps only drain the queue.
//
// The front end classifies bytes and keeps the escape phase, the partial
// hex value and the produced count, so the room check never waits on the
// output side. Errors produce a single word with end_of_string set, after
// which the rest of the string is swallowed up to its last byte.
module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        end_of_string,
  output logic [1:0]  status,
  output logic [15:0] out_length,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);
  import jsu_pkg::*;

  logic [15:0] capacity;
  logic        push, pop, q_empty, q_full;
  job_t        push_job, head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_fill;

  // Capacity register; the user must write it only while the unit is idle, as the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .capacity   (capacity),
    .queue_full (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full),
    .fill     (q_fill)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_string (end_of_string),
    .status        (status),
    .out_length    (out_length)
  );

`ifndef SYNTHESIS
  // The queue never holds more jobs than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("job queue overfilled");

  // A full queue must hold off the input side.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !in_ready)
    else $error("input accepted while job queue full");

  // An error word always ends the string and carries a failure code.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (end_of_string && status != ST_OK))
    else $error("error word without end mark or status");

  // A data word always reports success.
  a_data_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> (status == ST_OK))
    else $error("data word with failure status");
`endif

endmodule

[src/jsu_front.sv]
// Front end: accepts input bytes, tracks escape state and builds output jobs.
module jsu_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  input  logic         last_byte,
  input  logic [15:0]  capacity,
  input  logic         queue_full,
  output logic         push,
  output jsu_pkg::job_t push_job
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESCAPE = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX4 = 3'd5;

  logic [2:0]  phase, phase_next, phase_eff;
  logic [11:0] acc, acc_next;
  logic [15:0] count, count_next;
  logic        discarding, discarding_next;

  logic        accept;
  logic        do_fail, do_emit;
  logic [1:0]  fail_st, em_n;
  logic [7:0]  em_b0, em_b1, em_b2;
  logic [4:0]  hex;
  logic [15:0] cp;
  logic        room_fail;

  // Returns {ok, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign phase_eff = (phase > PH_HEX4) ? PH_NORMAL : phase;
  assign hex = hex_digit(in_byte);
  assign cp = {acc, hex[3:0]};
  assign room_fail = ({1'b0, count} + ROOM_MARGIN) >= {1'b0, capacity};

  // Classify the byte.
  always_comb begin
    do_fail = 1'b0;
    fail_st = ST_OK;
    do_emit = 1'b0;
    em_n = 2'd1;
    em_b0 = in_byte;
    em_b1 = 8'h00;
    em_b2 = 8'h00;
    phase_next = phase_eff;
    acc_next = acc;
    case (phase_eff)
      PH_NORMAL: begin
        if (room_fail) begin
          do_fail = 1'b1;
          fail_st = ST_ROOM;
        end else if (in_byte == 8'h5C) begin
          if (last_byte) begin
            do_fail = 1'b1;
            fail_st = ST_SHORT;
          end else begin
            phase_next = PH_ESCAPE;
          end
        end else begin
          do_emit = 1'b1;
        end
      end
      PH_ESCAPE: begin
        do_emit = 1'b1;
        phase_next = PH_NORMAL;
        case (in_byte)
          8'h22, 8'h5C, 8'h2F: em_b0 = in_byte;
          8'h6E: em_b0 = 8'h0A;
          8'h72: em_b0 = 8'h0D;
          8'h74: em_b0 = 8'h09;
          8'h62: em_b0 = 8'h08;
          8'h66: em_b0 = 8'h0C;
          8'h75: begin
            do_emit = 1'b0;
            if (last_byte) begin
              do_fail = 1'b1;
              fail_st = ST_SHORT;
            end else begin
              phase_next = PH_HEX1;
              acc_next = 12'd0;
            end
          end
          default: begin
            do_emit = 1'b0;
            do_fail = 1'b1;
            fail_st = ST_BAD;
          end
        endcase
      end
      default: begin
        if (!hex[4]) begin
          do_fail = 1'b1;
          fail_st = ST_BAD;
        end else if (phase_eff != PH_HEX4) begin
          acc_next = {acc[7:0], hex[3:0]};
          if (last_byte) begin
            do_fail = 1'b1;
            fail_st = ST_SHORT;
          end else begin
            phase_next = phase_eff + 3'd1;
          end
        end else begin
          do_emit = 1'b1;
          phase_next = PH_NORMAL;
          acc_next = 12'd0;
          if (cp < 16'h0080) begin
            em_n = 2'd1;
            em_b0 = cp[7:0];
          end else if (cp < 16'h0800) begin
            em_n = 2'd2;
            em_b0 = {3'b110, cp[10:6]};
            em_b1 = {2'b10, cp[5:0]};
          end else begin
            em_n = 2'd3;
            em_b0 = {4'b1110, cp[15:12]};
            em_b1 = {2'b10, cp[11:6]};
            em_b2 = {2'b10, cp[5:0]};
          end
        end
      end
    endcase
  end

  // Apply the outcome of an accepted byte.
  always_comb begin
    push = 1'b0;
    push_job = '0;
    push_job.len = count;
    count_next = count;
    discarding_next = discarding;
    if (accept && discarding) begin
      if (last_byte) begin
        discarding_next = 1'b0;
      end
    end else if (accept && do_fail) begin
      push = 1'b1;
      push_job.n = 2'd0;
      push_job.eos = 1'b1;
      push_job.status = fail_st;
      count_next = 16'd0;
      discarding_next = !last_byte;
    end else if (accept && do_emit) begin
      push = 1'b1;
      push_job.n = em_n;
      push_job.b0 = em_b0;
      push_job.b1 = em_b1;
      push_job.b2 = em_b2;
      push_job.eos = last_byte;
      push_job.status = ST_OK;
      count_next = last_byte ? 16'd0 : count + {14'd0, em_n};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      acc <= 12'd0;
      count <= 16'd0;
      discarding <= 1'b0;
    end else if (accept) begin
      discarding <= discarding_next;
      count <= count_next;
      if (discarding || do_fail || (do_emit && last_byte)) begin
        phase <= PH_NORMAL;
        acc <= 12'd0;
      end else begin
        phase <= phase_next;
        acc <= acc_next;
      end
    end
  end

endmodule

[src/jsu_queue.sv]
// Small job queue between the front end and the output stage.
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output jsu_pkg::job_t head,
  output logic          empty,
  output logic          full,
  output logic [$clog2(DEPTH+1)-1:0] fill
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign empty = (fill == '0);
  assign full = (fill == CW'(DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

[src/jsu_back.sv]
// Output stage: expands each job into one to three output words.
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  jsu_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          end_of_string,
  output logic [1:0]    status,
  output logic [15:0]   out_length
);
  import jsu_pkg::*;

  logic [1:0]  sub;
  logic        load, final_sub, is_err;
  logic [7:0]  sel_byte;

  assign is_err = (head.n == 2'd0);
  assign final_sub = is_err || (sub == head.n - 2'd1);
  assign load = !empty && (!out_valid || out_ready);
  assign pop = load && final_sub;

  always_comb begin
    case (sub)
      2'd0: sel_byte = head.b0;
      2'd1: sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub <= final_sub ? 2'd0 : sub + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= is_err ? 8'h00 : sel_byte;
      byte_valid <= !is_err;
      end_of_string <= head.eos && final_sub;
      status <= head.status;
      out_length <= is_err ? head.len : head.len + {14'd0, sub} + 16'd1;
    end
  end

endmodule

[tb/unescape_checker.sv]
// Checker that predicts and compares the output words of the JSON unescape unit.
`timescale 1ns / 1ps

module unescape_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        end_of_string,
  input  logic [1:0]  status,
  input  logic [15:0] out_length,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          pending
);
  import jsu_pkg::*;

  localparam int PRINT_CAP = 200;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_HEX3 = 3'd4,
    PH_HEX4 = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        eos;
    logic [1:0]  status;
    logic [15:0] len;
  } word_t;

  word_t       expected_words[$];
  phase_e      phase;
  logic [11:0] hex_acc;
  logic [15:0] byte_count;
  logic        swallowing;
  logic [15:0] capacity;

  task automatic report_mismatch(input string what);
    // Past the print cap mismatches are still counted.
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_string();
    phase = PH_TEXT;
    hex_acc = '0;
    byte_count = '0;
  endtask

  task automatic push_word(input logic [7:0] data, input logic valid, input logic eos,
                           input logic [1:0] st, input logic [15:0] len);
    word_t w;
    w.data = data;
    w.valid = valid;
    w.eos = eos;
    w.status = st;
    w.len = len;
    expected_words.push_back(w);
  endtask

  // An error word ends the string; the rest of it is dropped unless this was its last byte.
  task automatic fail_string(input logic [1:0] st, input logic last);
    push_word(8'h00, 1'b0, 1'b1, st, byte_count);
    clear_string();
    swallowing = !last;
  endtask

  // seq holds up to three bytes, the first one in the top byte.
  task automatic emit_bytes(input logic [23:0] seq, input int n, input logic last);
    for (int j = 0; j < n; j++) begin
      byte_count = byte_count + 16'd1;
      push_word(seq[23 - 8 * j -: 8], 1'b1, last && (j == n - 1), ST_OK, byte_count);
    end
    if (last)
      clear_string();
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9")
      return int'(c - "0");
    if (c >= "a" && c <= "f")
      return int'(c - "a") + 10;
    if (c >= "A" && c <= "F")
      return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic decode_input_byte(input logic [7:0] b, input logic last);
    int          h;
    logic [15:0] cp;
    if (swallowing) begin
      if (last) begin
        swallowing = 1'b0;
        clear_string();
      end
      return;
    end
    case (phase)
      PH_ESC: begin
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            phase = PH_TEXT;
            emit_bytes({b, 16'h0}, 1, last);
          end
          "n": begin phase = PH_TEXT; emit_bytes({8'h0A, 16'h0}, 1, last); end
          "r": begin phase = PH_TEXT; emit_bytes({8'h0D, 16'h0}, 1, last); end
          "t": begin phase = PH_TEXT; emit_bytes({8'h09, 16'h0}, 1, last); end
          "b": begin phase = PH_TEXT; emit_bytes({8'h08, 16'h0}, 1, last); end
          "f": begin phase = PH_TEXT; emit_bytes({8'h0C, 16'h0}, 1, last); end
          "u": begin
            if (last) begin
              fail_string(ST_SHORT, last);
            end else begin
              phase = PH_HEX1;
              hex_acc = '0;
            end
          end
          default: fail_string(ST_BAD, last);
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        h = hex_nibble(b);
        if (h < 0) begin
          fail_string(ST_BAD, last);
        end else if (phase != PH_HEX4) begin
          hex_acc = {hex_acc[7:0], 4'(h)};
          if (last)
            fail_string(ST_SHORT, last);
          else
            phase = phase_e'(phase + 3'd1);
        end else begin
          cp = {hex_acc, 4'(h)};
          phase = PH_TEXT;
          hex_acc = '0;
          if (cp < 16'h0080)
            emit_bytes({cp[7:0], 16'h0}, 1, last);
          else if (cp < 16'h0800)
            emit_bytes({3'b110, cp[10:6], 2'b10, cp[5:0], 8'h0}, 2, last);
          else
            emit_bytes({4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}, 3, last);
        end
      end
      default: begin
        // Text phase, also the landing place for any phase code with no meaning.
        phase = PH_TEXT;
        if ({1'b0, byte_count} + ROOM_MARGIN >= {1'b0, capacity})
          fail_string(ST_ROOM, last);
        else if (b == CH_BSLASH) begin
          if (last)
            fail_string(ST_SHORT, last);
          else
            phase = PH_ESC;
        end else
          emit_bytes({b, 16'h0}, 1, last);
      end
    endcase
  endtask

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      expected_words.delete();
      clear_string();
      swallowing = 1'b0;
      capacity = CAP_RESET;
      mismatch_count = 0;
    end else begin
      // The output is checked before the input is predicted: a result never
      // leaves in the cycle its byte enters.
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, out_byte %02h status %0d",
                                    out_byte, status));
        end else begin
          w = expected_words.pop_front();
          if (out_byte !== w.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, w.data));
          if (byte_valid !== w.valid)
            report_mismatch($sformatf("byte_valid %b, expected %b", byte_valid, w.valid));
          if (end_of_string !== w.eos)
            report_mismatch($sformatf("end_of_string %b, expected %b", end_of_string, w.eos));
          if (status !== w.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, w.status));
          if (out_length !== w.len)
            report_mismatch($sformatf("out_length %0d, expected %0d", out_length, w.len));
        end
      end
      if (cfg_write)
        capacity = cfg_data;
      if (in_valid && in_ready)
        decode_input_byte(in_byte, last_byte);
    end
    pending <= expected_words.size();
  end

endmodule

[tb/json_string_unescape_utf8_unit_test.sv]
// Testbench top for the JSON string unescape unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit_test;
  import jsu_pkg::*;

  // Cycles allowed with no word accepted on either channel. The slowest
  // correct stretch is a config drain or a long receiver stall, far below this.
  localparam int STALL_LIMIT = 2000;
  // Cycles let pass once nothing is expected, so that a byte that gave no
  // result (a backslash, a hex digit, a swallowed byte) has left the pipeline.
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = "u";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_string;
  logic [1:0]  status;
  logic [15:0] out_length;
  logic        cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'h0000;

  int          mismatch_count;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_cycles = 0;
  logic [7:0]  str_q[$];

  json_string_unescape_utf8_unit uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .end_of_string (end_of_string),
    .status        (status),
    .out_length    (out_length),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data)
  );

  unescape_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .end_of_string  (end_of_string),
    .status         (status),
    .out_length     (out_length),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // The watchdog ends a run that has stopped moving.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Sends one word. The sender may idle first; once valid is up it stays up
  // with the same payload until the word is taken.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // Sends a whole string body given as text, its final character marked last.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_string_queue();
    for (int i = 0; i < str_q.size(); i++)
      send_word(str_q[i], i == str_q.size() - 1);
  endtask

  // Waits until every expected word has come out and the pipeline has drained.
  // The first edge lets the checker count the word accepted last.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper_case);
    if (nib < 4'd10)
      return 8'("0") + 8'(nib);
    return (upper_case ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] escape_letter(input int sel);
    case (sel)
      0: return 8'h22;
      1: return CH_BSLASH;
      2: return 8'h2F;
      3: return "n";
      4: return "r";
      5: return "t";
      6: return "b";
      default: return "f";
    endcase
  endfunction

  task automatic push_hex_digits(input logic [15:0] cp, input int count);
    for (int i = 0; i < count; i++)
      str_q.push_back(hex_char(cp[15 - 4 * i -: 4], $urandom_range(1)));
  endtask

  // Builds one random string body in str_q. Most elements are well formed:
  // plain bytes, simple escapes and \u escapes of every UTF-8 length. The rest
  // are broken escapes; a cut-short escape always ends the string.
  task automatic make_random_string();
    int          n_elem;
    int          kind;
    int          good_digits;
    bit          cut_short;
    logic [15:0] cp;
    str_q.delete();
    cut_short = 1'b0;
    n_elem = $urandom_range(1, 6);
    for (int e = 0; e < n_elem && !cut_short; e++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        str_q.push_back(8'($urandom_range(255)));
      end else if (kind < 65) begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(escape_letter($urandom_range(7)));
      end else if (kind < 88) begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007F));
          1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
          default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        push_hex_digits(cp, 4);
      end else begin
        str_q.push_back(CH_BSLASH);
        case ($urandom_range(2))
          0: begin
            // Any byte after a backslash; mostly an unknown escape.
            str_q.push_back(8'($urandom_range(255)));
          end
          1: begin
            // A non-hex character in one of the four digit places.
            str_q.push_back(CH_U);
            good_digits = $urandom_range(3);
            push_hex_digits(16'($urandom_range(16'hFFFF)), good_digits);
            str_q.push_back(8'($urandom_range(8'h60, 8'h47)));
          end
          default: begin
            // The string stops after the backslash, after \u, or inside the digits.
            good_digits = $urandom_range(4);
            if (good_digits > 0) begin
              str_q.push_back(CH_U);
              push_hex_digits(16'($urandom_range(16'hFFFF)), good_digits - 1);
            end
            cut_short = 1'b1;
          end
        endcase
      end
    end
  endtask

  initial begin
    int phase_words;

    // Reset is held from the start and then released for good.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 29;
    rx_idle_pct = 45;

    // Directed part, at the reset capacity.
    // The lowest and highest plain bytes, the second one ending the string.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    // A simple escape, then a two-byte \u escape ending the string.
    send_text("\\n\\u07Ff");
    // Quote and slash escapes around a one-byte \u and a surrogate value.
    send_text("\\\"\\u0041\\uD80f\\/");
    // A backslash as the last byte, then \u as the last two bytes.
    send_text("\\");
    send_text("\\u");
    // A good second hex digit as the last byte cuts the escape short.
    send_text("\\u1A");
    // A bad hex digit as the last byte is a bad escape, not a short one.
    send_text("\\u12G");
    // A bad hex digit in the middle; the escape after it is swallowed.
    send_text("\\u0g\\x");
    // An unknown escape letter after two plain bytes.
    send_text("ab\\q");

    // Random part: six phases, each with its own capacity; the idling changes every second phase.
    // The capacities include the smallest one allowed and the largest.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0, 1: begin tx_idle_pct = 29; rx_idle_pct = 45; end
        2, 3: begin tx_idle_pct = 45; rx_idle_pct = 29; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      case (p)
        0: set_capacity(16'd6);
        1: set_capacity(16'hFFFF);
        2: set_capacity(16'd9);
        3: set_capacity(16'($urandom_range(40, 6)));
        4: set_capacity(16'($urandom_range(16'hFFFF, 6)));
        default: set_capacity(CAP_RESET);
      endcase
      phase_words = 0;
      while (phase_words < 4) begin
        make_random_string();
        send_string_queue();
        phase_words += str_q.size();
      end
    end

    wait_idle();
    @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[json_string_unescape_utf8_unit.f]
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8_unit.sv
tb/unescape_checker.sv
tb/json_string_unescape_utf8_unit_test.sv
